// ===== hw/rtl/wbs4_pkg.sv =====
// Shared constants, codes and types of the white-box SM4 table engine.
// No dependencies; the interface, top-level and checker files import this package.
`default_nettype none

package wbs4_pkg;

  // Round counts
  localparam int MAX_DUMMY_ROUNDS = 4;
  localparam int BASE_ROUNDS      = 32;
  localparam int GROUP_ROUNDS     = 4;
  localparam int MAX_ROUNDS       = BASE_ROUNDS + GROUP_ROUNDS * MAX_DUMMY_ROUNDS;

  // Bank organization: one bank per (group, lane); rows are rounds, then encodings
  localparam int NUM_GROUPS  = 6;
  localparam int NUM_LANES   = 4;
  localparam int NUM_POS     = 4;
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 8;
  localparam int LANE_W      = 2;
  localparam int GRP_W       = $clog2(NUM_GROUPS);
  localparam int ROWS        = MAX_ROUNDS + 2;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int RND_W       = $clog2(MAX_ROUNDS);
  localparam int DR_W        = $clog2(MAX_DUMMY_ROUNDS + 2);
  localparam int BANK_DEPTH  = ROWS * (2 ** ENTRY_W);
  localparam int BANK_AW     = ROW_W + ENTRY_W;

  localparam logic [ROW_W-1:0] ROW_IN_ENC  = ROW_W'(MAX_ROUNDS);
  localparam logic [ROW_W-1:0] ROW_OUT_ENC = ROW_W'(MAX_ROUNDS + 1);

  // Register file
  localparam int DUMMY_W   = 3;
  localparam int PADDR_W   = 3;
  localparam logic REG_DUMMY_ROUNDS = 1'b0;

  // Bank groups within a round
  localparam logic [GRP_W-1:0] GRP_MIX0  = GRP_W'(0);
  localparam logic [GRP_W-1:0] GRP_MIX1  = GRP_W'(1);
  localparam logic [GRP_W-1:0] GRP_MIX2  = GRP_W'(2);
  localparam logic [GRP_W-1:0] GRP_ROUND = GRP_W'(3);
  localparam logic [GRP_W-1:0] GRP_C     = GRP_W'(4);
  localparam logic [GRP_W-1:0] GRP_D     = GRP_W'(5);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_BLOCK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_IN_ENC  = 3'd0,
    KIND_OUT_ENC = 3'd1,
    KIND_MIX0    = 3'd2,
    KIND_MIX1    = 3'd3,
    KIND_MIX2    = 3'd4,
    KIND_ROUND   = 3'd5,
    KIND_C       = 3'd6,
    KIND_D       = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IN_ENC,
    ST_RND_A,
    ST_RND_B,
    ST_RND_C,
    ST_OUT_ENC
  } state_e;

  typedef logic [WORD_W-1:0] word_t;

  // Byte that indexes a lane; lane 0 takes the most significant byte
  function automatic logic [ENTRY_W-1:0] lane_byte(input word_t w, input int lane);
    return w[WORD_W-1-ENTRY_W*lane -: ENTRY_W];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wbs4_if.sv =====
// Valid/ready stream interfaces for block items and result items.
// Depends on wbs4_pkg for field widths.
`default_nettype none

interface wbs4_in_if
  import wbs4_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [2:0]         table_kind;
  logic [5:0]         table_round;
  logic [LANE_W-1:0]  table_lane;
  logic [ENTRY_W-1:0] table_entry;
  logic [WORD_W-1:0]  table_word;
  logic [63:0]        block_hi;
  logic [63:0]        block_lo;

  modport source (output valid, cmd, table_kind, table_round, table_lane, table_entry,
                  table_word, block_hi, block_lo, input ready);
  modport sink   (input valid, cmd, table_kind, table_round, table_lane, table_entry,
                  table_word, block_hi, block_lo, output ready);
endinterface

interface wbs4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wbs4_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; used for each table bank of the top level.
`default_nettype none

module wbs4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; hold the last word when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/white_box_sm4_block_cipher_core.sv =====
// Top level of the white-box SM4 table engine: sequencer, banked table store, APB register.
// Depends on wbs4_pkg, wbs4_if and wbs4_ram.
//
// Usage
//   blk_in_i carries items. cmd = load writes table_word into the table chosen by
//   table_kind/table_round/table_lane at table_entry and yields no result. cmd = block
//   encodes block_hi/block_lo through the loaded tables and yields one result
//   transaction on res_out_o.
//   The APB port holds dummy_rounds at address 0; write it only while idle.
//   A block runs R = 32 + 4 * dummy_rounds rounds (dummy_rounds saturates at
//   4) between the input and output encoding lookups; the engine accepts
//   the next item once the result is loaded. Each round needs three dependent
//   table lookups (mixing and C tables, then the round table, then the D table),
//   each through a memory with a registered read port; that chain sets the
//   latency. A load item leaves the engine idle and ready.
//   A finished result sits in an output register; the engine accepts the next
//   item while it waits. If the receiver still stalls when the following result
//   is ready, the engine holds that result in its last step and accepts nothing.
//   Reset clears the sequencer, the output valid and dummy_rounds; the table
//   banks are not cleared and must be loaded before use.
`default_nettype none

module white_box_sm4_block_cipher_core
  import wbs4_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  wbs4_in_if.sink                 blk_in_i,
  wbs4_out_if.source              res_out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  state_e                 state_q, state_d;
  logic [RND_W-1:0]       round_q, round_d;
  logic [RND_W-1:0]       last_q, last_d;
  word_t                  x_q [NUM_POS];
  word_t                  x_d [NUM_POS];
  word_t                  c_q, c_d;
  logic [DUMMY_W-1:0]     dummy_q;
  logic                   out_valid_q, out_valid_d;
  logic [63:0]            res_hi_q, res_lo_q;
  logic                   load_out;
  logic                   in_ready;
  logic                   in_acc;

  logic [NUM_GROUPS-1:0]  grp_re;
  word_t                  grp_key [NUM_GROUPS];
  logic [ROW_W-1:0]       iss_row;
  word_t                  rdata [NUM_GROUPS][NUM_LANES];
  word_t                  grp_val [NUM_GROUPS];

  logic                   wr_en;
  logic [GRP_W-1:0]       wr_grp;
  logic [ROW_W-1:0]       wr_row;
  logic [BANK_AW-1:0]     wr_addr;
  logic [DR_W-1:0]        dr_sat;

  assign in_acc = blk_in_i.valid && in_ready;

  // APB register: always ready, write in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DUMMY_ROUNDS) ? {{(32-DUMMY_W){1'b0}}, dummy_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dummy_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DUMMY_ROUNDS)) begin
      dummy_q <= pwdata[DUMMY_W-1:0];
    end
  end

  // Saturate the extra round groups
  assign dr_sat = (int'(dummy_q) > MAX_DUMMY_ROUNDS) ? DR_W'(MAX_DUMMY_ROUNDS)
                                                      : DR_W'(dummy_q);

  // Decode a table load into bank group, lane and row
  always_comb begin
    wr_en  = 1'b0;
    wr_grp = '0;
    wr_row = '0;
    if (in_acc && (blk_in_i.cmd == CMD_LOAD)) begin
      if ((blk_in_i.table_kind == KIND_IN_ENC) || (blk_in_i.table_kind == KIND_OUT_ENC)) begin
        wr_en  = (blk_in_i.table_round[5:2] == 4'd0);
        wr_grp = GRP_W'(blk_in_i.table_round[1:0]);
        wr_row = (blk_in_i.table_kind == KIND_IN_ENC) ? ROW_IN_ENC : ROW_OUT_ENC;
      end else begin
        wr_en  = (int'(blk_in_i.table_round) < MAX_ROUNDS);
        wr_grp = GRP_W'(blk_in_i.table_kind - KIND_MIX0);
        wr_row = ROW_W'(blk_in_i.table_round);
      end
    end
  end

  assign wr_addr = {wr_row, blk_in_i.table_entry};

  // Table banks, one per group and lane
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic               bank_we;
      logic [BANK_AW-1:0] bank_raddr;

      assign bank_we    = wr_en && (wr_grp == GRP_W'(g)) &&
                          (blk_in_i.table_lane == LANE_W'(l));
      assign bank_raddr = {iss_row, lane_byte(grp_key[g], l)};

      wbs4_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk_i   (clk_i),
        .we_i    (bank_we),
        .waddr_i (wr_addr),
        .wdata_i (blk_in_i.table_word),
        .re_i    (grp_re[g]),
        .raddr_i (bank_raddr),
        .rdata_o (rdata[g][l])
      );
    end
  end

  // Fold the four lanes of each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_val[g] = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        grp_val[g] = grp_val[g] ^ rdata[g][l];
      end
    end
  end

  // Sequencer: issue lookups, fold returned words, shift the window
  always_comb begin
    state_d  = state_q;
    round_d  = round_q;
    last_d   = last_q;
    c_d      = c_q;
    x_d      = x_q;
    grp_re   = '0;
    iss_row  = '0;
    load_out = 1'b0;
    in_ready = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_key[g] = '0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (blk_in_i.valid && (blk_in_i.cmd == CMD_BLOCK)) begin
          grp_re[NUM_POS-1:0] = '1;
          grp_key[0] = blk_in_i.block_hi[63:32];
          grp_key[1] = blk_in_i.block_hi[31:0];
          grp_key[2] = blk_in_i.block_lo[63:32];
          grp_key[3] = blk_in_i.block_lo[31:0];
          iss_row    = ROW_IN_ENC;
          round_d    = '0;
          last_d     = RND_W'(BASE_ROUNDS - 1 + GROUP_ROUNDS * int'(dr_sat));
          state_d    = ST_IN_ENC;
        end
      end

      ST_IN_ENC: begin
        for (int p = 0; p < NUM_POS; p++) begin
          x_d[p] = grp_val[p];
        end
        grp_re[GRP_MIX0]  = 1'b1;
        grp_re[GRP_MIX1]  = 1'b1;
        grp_re[GRP_MIX2]  = 1'b1;
        grp_re[GRP_C]     = 1'b1;
        grp_key[GRP_MIX0] = x_d[1];
        grp_key[GRP_MIX1] = x_d[2];
        grp_key[GRP_MIX2] = x_d[3];
        grp_key[GRP_C]    = x_d[0];
        iss_row           = ROW_W'(round_q);
        state_d           = ST_RND_A;
      end

      ST_RND_A: begin
        // Mixing groups give t; hold the C lookup for the end of the round
        c_d                = grp_val[GRP_C];
        grp_re[GRP_ROUND]  = 1'b1;
        grp_key[GRP_ROUND] = grp_val[GRP_MIX0] ^ grp_val[GRP_MIX1] ^ grp_val[GRP_MIX2];
        iss_row            = ROW_W'(round_q);
        state_d            = ST_RND_B;
      end

      ST_RND_B: begin
        grp_re[GRP_D]  = 1'b1;
        grp_key[GRP_D] = grp_val[GRP_ROUND];
        iss_row        = ROW_W'(round_q);
        state_d        = ST_RND_C;
      end

      ST_RND_C: begin
        x_d[0] = x_q[1];
        x_d[1] = x_q[2];
        x_d[2] = x_q[3];
        x_d[3] = c_q ^ grp_val[GRP_D];
        if (round_q == last_q) begin
          // Output encoding: position p takes window word 3 - p
          grp_re[NUM_POS-1:0] = '1;
          grp_key[0] = x_d[3];
          grp_key[1] = x_d[2];
          grp_key[2] = x_d[1];
          grp_key[3] = x_d[0];
          iss_row    = ROW_OUT_ENC;
          state_d    = ST_OUT_ENC;
        end else begin
          round_d           = round_q + 1'b1;
          grp_re[GRP_MIX0]  = 1'b1;
          grp_re[GRP_MIX1]  = 1'b1;
          grp_re[GRP_MIX2]  = 1'b1;
          grp_re[GRP_C]     = 1'b1;
          grp_key[GRP_MIX0] = x_d[1];
          grp_key[GRP_MIX1] = x_d[2];
          grp_key[GRP_MIX2] = x_d[3];
          grp_key[GRP_C]    = x_d[0];
          iss_row           = ROW_W'(round_d);
          state_d           = ST_RND_A;
        end
      end

      ST_OUT_ENC: begin
        // Hold here until the output register is free
        if (!out_valid_q || res_out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      last_q  <= last_d;
    end
  end

  // Window and C word carry no reset
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    c_q <= c_d;
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_hi_q <= {grp_val[0], grp_val[1]};
      res_lo_q <= {grp_val[2], grp_val[3]};
    end
  end

  assign blk_in_i.ready      = in_ready;
  assign res_out_o.valid     = out_valid_q;
  assign res_out_o.result_hi = res_hi_q;
  assign res_out_o.result_lo = res_lo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wbs4_checker.sv =====
// Port-level assertions for the white-box SM4 engine, bound to the top level.
// Depends on wbs4_pkg and white_box_sm4_block_cipher_core.
`default_nettype none

module wbs4_checker
  import wbs4_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_cmd_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_hi_i,
  input wire logic [63:0] result_lo_i
);

  // A block transaction occupies the engine on the next cycle
  a_block_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_cmd_i == CMD_BLOCK)) |=> !in_ready_i)
    else $error("engine ready right after a block transaction");

  // A load transaction leaves the engine ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_cmd_i == CMD_LOAD)) |=> in_ready_i)
    else $error("engine not ready after a load transaction");

  // A result is raised only when the engine was busy just before it
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result raised without a busy cycle before it");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(result_hi_i) && $stable(result_lo_i)))
    else $error("stalled result changed");

endmodule

bind white_box_sm4_block_cipher_core wbs4_checker u_wbs4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (blk_in_i.valid),
  .in_ready_i  (blk_in_i.ready),
  .in_cmd_i    (blk_in_i.cmd),
  .out_valid_i (res_out_o.valid),
  .out_ready_i (res_out_o.ready),
  .result_hi_i (res_out_o.result_hi),
  .result_lo_i (res_out_o.result_lo)
);

`default_nettype wire

// ===== dv/tb_white_box_sm4_block_cipher_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the white-box SM4 table engine: loads tables, streams blocks,
// and compares each result with its own table-driven predictor.
// Depends on wbs4_pkg, the wbs4_in_if / wbs4_out_if interfaces and the core RTL.

module tb_white_box_sm4_block_cipher_core;
  import wbs4_pkg::*;

  // Flat table layout of the predictor mirror
  localparam int unsigned TBL_ENC_WORDS   = 8192;
  localparam int unsigned TBL_ROUND_WORDS = 6144;
  localparam int unsigned TBL_WORDS       = TBL_ENC_WORDS + MAX_ROUNDS * TBL_ROUND_WORDS;

  localparam logic [PADDR_W-1:0] ADDR_DUMMY  = PADDR_W'(4 * REG_DUMMY_ROUNDS);
  localparam int                 REG_UNUSED  = 1;
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4 * REG_UNUSED);

  localparam int    NUM_STEPS       = 8;
  localparam int    ITEMS_PER_STEP  = 100;
  localparam int    SETTLE_CYCLES   = 3 * MAX_ROUNDS + 8;
  localparam int    HOLD_AFTER_BLKS = 40;
  localparam int    HOLD_CYCLES     = 1000;
  localparam longint LIMIT_NS       = 20_000_000;
  // Bytes outside the closed set; any read of them would hit an entry outside the loaded set
  localparam word_t POISON_WORD     = 32'h0102_0408;

  typedef struct packed {
    cmd_e        cmd;
    kind_e       kind;
    logic [5:0]  rnd;
    logic [1:0]  lane;
    logic [7:0]  entry;
    word_t       word;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
  } wb_item_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } wb_block_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wbs4_in_if  blk_in ();
  wbs4_out_if res_out ();

  white_box_sm4_block_cipher_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_in_i  (blk_in),
    .res_out_o (res_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: mirror of the table store and the round register
  bit   [31:0] tbl_mirror [TBL_WORDS];
  logic [2:0]  dummy_cfg = '0;

  wb_item_t    stim_q[$];
  wb_block_t   expected_blocks[$];
  wb_item_t    in_flight;
  int          n_errors    = 0;
  int unsigned n_blocks_in = 0;
  int          src_gap     = 0;
  int          snk_gap     = 0;
  logic        hold_off    = 1'b0;
  logic        calm        = 1'b0;

  // Tables are filled at every entry whose high nibble is the bit-reverse of the low
  // nibble. That set is closed under XOR, so blocks built from it never reach an
  // entry that was never loaded.
  function automatic logic [7:0] set_byte(logic [3:0] n);
    return {n, n[0], n[1], n[2], n[3]};
  endfunction

  function automatic logic in_set(logic [7:0] b);
    return b[3:0] == {b[4], b[5], b[6], b[7]};
  endfunction

  function automatic word_t set_word();
    return {set_byte(4'($urandom)), set_byte(4'($urandom)),
            set_byte(4'($urandom)), set_byte(4'($urandom))};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic wb_item_t mk_load(kind_e k, int unsigned r, int unsigned ln,
                                       logic [7:0] e, word_t w);
    wb_item_t it;
    it.cmd    = CMD_LOAD;
    it.kind   = k;
    it.rnd    = 6'(r);
    it.lane   = 2'(ln);
    it.entry  = e;
    it.word   = w;
    it.blk_hi = {$urandom(), $urandom()};
    it.blk_lo = {$urandom(), $urandom()};
    return it;
  endfunction

  function automatic wb_item_t mk_block(logic [63:0] hi, logic [63:0] lo);
    wb_item_t it;
    it.cmd    = CMD_BLOCK;
    it.kind   = kind_e'($urandom_range(0, 7));
    it.rnd    = 6'($urandom);
    it.lane   = 2'($urandom);
    it.entry  = 8'($urandom);
    it.word   = $urandom();
    it.blk_hi = hi;
    it.blk_lo = lo;
    return it;
  endfunction

  // Mostly blocks over the closed set; loads hit live, ignored and never-read entries
  function automatic wb_item_t rand_item();
    kind_e       k;
    int unsigned r;
    logic [7:0]  e;
    logic        live;
    if ($urandom_range(0, 9) < 7)
      return mk_block({set_word(), set_word()}, {set_word(), set_word()});
    k = kind_e'($urandom_range(0, 7));
    if (k == KIND_IN_ENC || k == KIND_OUT_ENC) begin
      r    = ($urandom_range(0, 4) == 0) ? $urandom_range(NUM_POS, 63) : $urandom_range(0, 3);
      live = r < NUM_POS;
    end else begin
      r    = ($urandom_range(0, 6) == 0) ? $urandom_range(MAX_ROUNDS, 63)
                                         : $urandom_range(0, MAX_ROUNDS - 1);
      live = r < MAX_ROUNDS;
    end
    e = $urandom_range(0, 1) ? set_byte(4'($urandom)) : 8'($urandom);
    return mk_load(k, r, $urandom_range(0, 3), e,
                   (live && in_set(e)) ? set_word() : word_t'($urandom()));
  endfunction

  function automatic int unsigned enc_base(kind_e k, int unsigned pos);
    return int'(k) * 4096 + pos * 1024;
  endfunction

  function automatic int unsigned round_base(int unsigned r, int unsigned grp);
    return TBL_ENC_WORDS + r * TBL_ROUND_WORDS + grp * 1024;
  endfunction

  // XOR of the four byte-indexed lane lookups of one table
  function automatic word_t lane_lookup(int unsigned base, word_t x);
    word_t       acc;
    int unsigned a;
    acc = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      a = base + l * 256 + x[31 - 8 * l -: 8];
      if (a < TBL_WORDS) acc ^= tbl_mirror[a];
    end
    return acc;
  endfunction

  // Apply one accepted transaction: update the mirror or queue the encrypted block
  function automatic void sm4_absorb(wb_item_t it);
    int unsigned addr;
    int unsigned nrnd;
    word_t       x[4];
    word_t       t, u, c, d;
    wb_block_t   res;
    if (it.cmd == CMD_LOAD) begin
      if (it.kind == KIND_IN_ENC || it.kind == KIND_OUT_ENC) begin
        if (it.rnd >= NUM_POS) return;
        addr = enc_base(it.kind, it.rnd);
      end else begin
        if (it.rnd >= MAX_ROUNDS) return;
        addr = round_base(it.rnd, int'(it.kind) - int'(KIND_MIX0));
      end
      addr += it.lane * 256 + it.entry;
      if (addr < TBL_WORDS) tbl_mirror[addr] = it.word;
      return;
    end
    nrnd = BASE_ROUNDS + GROUP_ROUNDS *
           ((dummy_cfg > MAX_DUMMY_ROUNDS) ? MAX_DUMMY_ROUNDS : int'(dummy_cfg));
    x[0] = it.blk_hi[63:32];
    x[1] = it.blk_hi[31:0];
    x[2] = it.blk_lo[63:32];
    x[3] = it.blk_lo[31:0];
    for (int i = 0; i < NUM_POS; i++) x[i] = lane_lookup(enc_base(KIND_IN_ENC, i), x[i]);
    for (int unsigned i = 0; i < nrnd; i++) begin
      t = lane_lookup(round_base(i, GRP_MIX0), x[1])
        ^ lane_lookup(round_base(i, GRP_MIX1), x[2])
        ^ lane_lookup(round_base(i, GRP_MIX2), x[3]);
      u = lane_lookup(round_base(i, GRP_ROUND), t);
      c = lane_lookup(round_base(i, GRP_C), x[0]);
      d = lane_lookup(round_base(i, GRP_D), u);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = c ^ d;
    end
    res.hi = {lane_lookup(enc_base(KIND_OUT_ENC, 0), x[3]),
              lane_lookup(enc_base(KIND_OUT_ENC, 1), x[2])};
    res.lo = {lane_lookup(enc_base(KIND_OUT_ENC, 2), x[1]),
              lane_lookup(enc_base(KIND_OUT_ENC, 3), x[0])};
    expected_blocks.push_back(res);
  endfunction

  function automatic void check_block(logic [63:0] hi, logic [63:0] lo);
    wb_block_t exp_blk;
    if (expected_blocks.size() == 0) begin
      $display("%0t: unexpected result transaction %h %h", $time, hi, lo);
      n_errors++;
      return;
    end
    exp_blk = expected_blocks.pop_front();
    if (hi !== exp_blk.hi) begin
      $display("%0t: result_hi mismatch: expected %h, actual %h", $time, exp_blk.hi, hi);
      n_errors++;
    end
    if (lo !== exp_blk.lo) begin
      $display("%0t: result_lo mismatch: expected %h, actual %h", $time, exp_blk.lo, lo);
      n_errors++;
    end
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: offer queued transactions, hold each until accepted, then idle a while
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      blk_in.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (blk_in.valid && blk_in.ready) begin
        sm4_absorb(in_flight);
        if (in_flight.cmd == CMD_BLOCK) n_blocks_in <= n_blocks_in + 1;
      end
      if (!blk_in.valid || blk_in.ready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          blk_in.valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          in_flight = stim_q.pop_front();
          blk_in.cmd         <= in_flight.cmd;
          blk_in.table_kind  <= in_flight.kind;
          blk_in.table_round <= in_flight.rnd;
          blk_in.table_lane  <= in_flight.lane;
          blk_in.table_entry <= in_flight.entry;
          blk_in.table_word  <= in_flight.word;
          blk_in.block_hi    <= in_flight.blk_hi;
          blk_in.block_lo    <= in_flight.blk_lo;
          blk_in.valid       <= 1'b1;
          src_gap = pick_gap();
        end else begin
          blk_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and stall the output at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_out.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (res_out.valid && res_out.ready) check_block(res_out.result_hi, res_out.result_lo);
      if (hold_off) begin
        res_out.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= 1'b1;
        snk_gap = pick_gap();
      end
    end
  end

  // Long receiver hold-off so the engine backs up and stalls its input
  initial begin
    do @(posedge clk_i); while (n_blocks_in < HOLD_AFTER_BLKS);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the round register, poke the unused address, and read back
  task automatic set_dummy_rounds(logic [2:0] val);
    logic [31:0] rd;
    apb_write(ADDR_DUMMY, {29'($urandom()), val});
    dummy_cfg = val;
    apb_write(ADDR_UNUSED, $urandom());
    apb_read(ADDR_DUMMY, rd);
    if (rd !== {29'd0, val}) begin
      $display("%0t: dummy_rounds readback mismatch: expected %h, actual %h",
               $time, {29'd0, val}, rd);
      n_errors++;
    end
  endtask

  // Hold until every transaction is accepted and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (stim_q.size() != 0 || blk_in.valid || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] step_cfg [NUM_STEPS];
    wb_item_t   it;
    step_cfg = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd5, 3'd1, 3'd3, 3'd6};

    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    blk_in.valid       = 1'b0;
    blk_in.cmd         = CMD_LOAD;
    blk_in.table_kind  = KIND_IN_ENC;
    blk_in.table_round = '0;
    blk_in.table_lane  = '0;
    blk_in.table_entry = '0;
    blk_in.table_word  = '0;
    blk_in.block_hi    = '0;
    blk_in.block_lo    = '0;
    res_out.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int s = 0; s < NUM_STEPS; s++) begin
      if (s > 0) wait_drained();
      set_dummy_rounds(step_cfg[s]);
      calm <= (s == 3 || s == 6);

      if (s == 0) begin
        // Load every set entry of every table, rounds up to the maximum
        for (int k = int'(KIND_IN_ENC); k <= int'(KIND_OUT_ENC); k++)
          for (int p = 0; p < NUM_POS; p++)
            for (int l = 0; l < NUM_LANES; l++)
              for (int n = 0; n < 16; n++)
                stim_q.push_back(mk_load(kind_e'(k), p, l, set_byte(4'(n)), set_word()));
        for (int r = 0; r < MAX_ROUNDS; r++)
          for (int k = int'(KIND_MIX0); k <= int'(KIND_D); k++)
            for (int l = 0; l < NUM_LANES; l++)
              for (int n = 0; n < 16; n++)
                stim_q.push_back(mk_load(kind_e'(k), r, l, set_byte(4'(n)), set_word()));

        // Directed: extreme blocks and words, ignored loads, unused fields
        stim_q.push_back(mk_block('0, '0));
        stim_q.push_back(mk_block('1, '1));
        stim_q.push_back(mk_load(KIND_IN_ENC, 0, 0, 8'hff, 32'hffff_ffff));
        stim_q.push_back(mk_load(KIND_IN_ENC, 3, 3, 8'h00, 32'h0000_0000));
        stim_q.push_back(mk_load(KIND_OUT_ENC, 0, 0, 8'hff, 32'hffff_ffff));
        stim_q.push_back(mk_block('1, '1));
        stim_q.push_back(mk_block('0, '0));
        // Encoding position out of range: dropped
        stim_q.push_back(mk_load(KIND_IN_ENC, NUM_POS, 0, 8'h00, POISON_WORD));
        stim_q.push_back(mk_load(KIND_OUT_ENC, 63, 3, 8'hff, POISON_WORD));
        // Round beyond the store: dropped
        stim_q.push_back(mk_load(KIND_MIX0, MAX_ROUNDS, 0, 8'h00, POISON_WORD));
        stim_q.push_back(mk_load(KIND_D, 63, 3, 8'hff, POISON_WORD));
        stim_q.push_back(mk_load(KIND_ROUND, MAX_ROUNDS - 1, 2, set_byte(4'd5), set_word()));
        // Entry outside the set is never read, so any word will do
        stim_q.push_back(mk_load(KIND_C, 0, 1, 8'h01, 32'hffff_ffff));
        // Block carrying load fields at their extremes
        it        = mk_block({set_word(), set_word()}, {set_word(), set_word()});
        it.kind   = KIND_D;
        it.rnd    = '1;
        it.lane   = '1;
        it.entry  = '1;
        it.word   = POISON_WORD;
        stim_q.push_back(it);
        // Load carrying block fields at their extremes
        it        = mk_load(KIND_MIX2, 17, 1, set_byte(4'd9), set_word());
        it.blk_hi = '1;
        it.blk_lo = '1;
        stim_q.push_back(it);
        stim_q.push_back(mk_block({32'hffff_ffff, set_word()}, {set_word(), 32'h0}));
        for (int i = 0; i < 4; i++)
          stim_q.push_back(mk_block({set_word(), set_word()}, {set_word(), set_word()}));
      end

      for (int i = 0; i < ITEMS_PER_STEP; i++) stim_q.push_back(rand_item());
    end

    wait_drained();
    if (n_errors == 0 && expected_blocks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
